>>> rtl/b64d_pkg.sv
// Shared types, constants and the character map of the base64 stream decoder.
`default_nettype none
package b64d_pkg;

    typedef struct packed {
        logic [7:0] char_in;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       byte_valid;
        logic       end_of_string;
    } t_out_item;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_stat;

    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_FOURTH = 2'd3;

    localparam logic [5:0] SEXTET_INVALID = 6'h3f;
    localparam logic [5:0] SEXTET_PLUS    = 6'd62;
    localparam logic [5:0] SEXTET_SLASH   = 6'd63;

    // Map a character to {ok, sextet}; invalid ones: ok low, sextet all ones.
    function automatic logic [6:0] map_char(input logic [7:0] c);
        logic [7:0] v;
        logic       ok;
        v  = 8'(SEXTET_INVALID);
        ok = 1'b1;
        if (c >= 8'h41 && c <= 8'h5a) begin
            v = c - 8'h41;
        end else if (c >= 8'h61 && c <= 8'h7a) begin
            v = c - 8'h61 + 8'd26;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30 + 8'd52;
        end else if (c == 8'h2b || c == 8'h2d) begin
            v = 8'(SEXTET_PLUS);
        end else if (c == 8'h2f || c == 8'h5f) begin
            v = 8'(SEXTET_SLASH);
        end else begin
            ok = 1'b0;
        end
        return {ok, v[5:0]};
    endfunction

endpackage
`default_nettype wire

>>> rtl/b64d_front.sv
// Front part: accepts characters, maps them and forms the decoded results.
`default_nettype none
module b64d_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire b64d_pkg::t_in_item   i_in_item,
    input  wire b64d_pkg::t_q_stat    i_q_stat,
    output logic                      o_in_stall,
    output logic                      o_push,
    output b64d_pkg::t_out_item       o_push_item
);
    import b64d_pkg::*;

    logic [1:0] r_group_pos, n_group_pos;
    logic [5:0] r_prev, n_prev;
    logic       accept;
    logic [6:0] mapped;
    logic       cur_ok;
    logic [5:0] cur;
    logic [7:0] byte_val;
    logic       has_byte;

    assign o_in_stall = i_q_stat.full;
    assign accept     = i_in_valid && !i_q_stat.full;
    assign mapped     = map_char(i_in_item.char_in);
    assign cur_ok     = mapped[6];
    assign cur        = mapped[5:0];

    always_comb begin
        byte_val = 8'h00;
        has_byte = 1'b0;
        unique case (r_group_pos)
            POS_FIRST: begin
                byte_val = 8'h00;
                has_byte = 1'b0;
            end
            POS_SECOND: begin
                byte_val = {r_prev, cur[5:4]};
                has_byte = cur_ok;
            end
            POS_THIRD: begin
                byte_val = {r_prev[3:0], cur[5:2]};
                has_byte = cur_ok;
            end
            POS_FOURTH: begin
                byte_val = {r_prev[1:0], cur};
                has_byte = cur_ok;
            end
            default: begin
                byte_val = 8'h00;
                has_byte = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_group_pos = r_group_pos;
        n_prev      = r_prev;
        if (accept) begin
            if (i_in_item.is_last) begin
                n_group_pos = POS_FIRST;
                n_prev      = 6'h00;
            end else begin
                n_group_pos = r_group_pos + 2'd1;
                n_prev      = cur;
            end
        end
    end

    assign o_push                    = accept && (has_byte || i_in_item.is_last);
    assign o_push_item.byte_out      = has_byte ? byte_val : 8'h00;
    assign o_push_item.byte_valid    = has_byte;
    assign o_push_item.end_of_string = i_in_item.is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_pos <= POS_FIRST;
            r_prev      <= 6'h00;
        end else begin
            r_group_pos <= n_group_pos;
            r_prev      <= n_prev;
        end
    end

endmodule
`default_nettype wire

>>> rtl/b64d_queue.sv
// Two-entry result queue between the front and the back.
`default_nettype none
module b64d_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire b64d_pkg::t_out_item  i_push_item,
    input  wire logic                 i_pop,
    output b64d_pkg::t_out_item       o_head_item,
    output b64d_pkg::t_q_stat         o_q_stat
);
    import b64d_pkg::*;

    t_out_item  r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       do_push, do_pop;

    assign o_q_stat.full      = (r_count == 2'd2);
    assign o_q_stat.not_empty = (r_count != 2'd0);
    assign o_head_item        = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_q_stat.full;
    assign do_pop  = i_pop && o_q_stat.not_empty;

    always_comb begin
        n_count = r_count;
        priority if (do_push && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/b64d_back.sv
// Back part: output register that delivers queued results downstream.
`default_nettype none
module b64d_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire b64d_pkg::t_q_stat    i_q_stat,
    input  wire b64d_pkg::t_out_item  i_head_item,
    input  wire logic                 i_out_stall,
    output logic                      o_pop,
    output logic                      o_out_valid,
    output b64d_pkg::t_out_item       o_out_item
);
    import b64d_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    // Refill when the register is empty or its request leaves this cycle.
    assign o_pop       = i_q_stat.not_empty && (!r_valid || !i_out_stall);
    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_head_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

endmodule
`default_nettype wire

>>> rtl/base64_stream_decoder_top.sv
// Top level of the base64 stream decoder: front, result queue and output stage.
// Throughput: one character per cycle, also while the output is stalled until
// the two-entry result queue fills. A result is written into the queue when its
// character is accepted, then loaded into the output register once that register is free.
// Characters that make no result leave no trace downstream.
// Reset (synchronous, active low) clears group position, previous sextet,
// queue pointers and output valid.
`default_nettype none
module base64_stream_decoder_top (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire b64d_pkg::t_in_item   i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output b64d_pkg::t_out_item       o_out_item
);
    import b64d_pkg::*;

    t_q_stat   q_stat;
    t_out_item push_item;
    t_out_item head_item;
    logic      push;
    logic      pop;

    b64d_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .i_q_stat    (q_stat),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_push_item (push_item)
    );

    b64d_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .i_pop       (pop),
        .o_head_item (head_item),
        .o_q_stat    (q_stat)
    );

    b64d_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_head_item (head_item),
        .i_out_stall (i_out_stall),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && q_stat.full))
        else $error("result pushed into a full queue");

    a_last_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_item.is_last) |-> push)
        else $error("last character produced no end marker");

    a_out_meaningful: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_item.byte_valid || o_out_item.end_of_string) &&
                         (o_out_item.byte_valid || o_out_item.byte_out == 8'h00)))
        else $error("output result carries neither byte nor end marker");
`endif

endmodule
`default_nettype wire

>>> tb/sv/base64_stream_decoder_top_tb.sv
// Self-checking testbench for the base64 stream decoder: directed and random strings.
`timescale 1ns / 1ps

import b64d_pkg::*;

class decode_tracker;
    logic [1:0]  group_pos;
    logic [5:0]  prev_sextet;
    t_out_item   pending_q[$];
    int unsigned mismatches;
    int unsigned chars_seen;
    int unsigned bytes_seen;
    int unsigned ends_seen;

    function new();
        group_pos   = POS_FIRST;
        prev_sextet = '0;
        mismatches  = 0;
        chars_seen  = 0;
        bytes_seen  = 0;
        ends_seen   = 0;
    endfunction

    // Advance the decode state for one accepted request and queue its result.
    function void note_char(t_in_item req);
        logic [7:0] c;
        logic [5:0] cur;
        logic       ok;
        logic [7:0] b;
        logic       has_byte;
        t_out_item  res;
        c  = req.char_in;
        ok = 1'b1;
        if (c >= "A" && c <= "Z") begin
            cur = 6'(c - "A");
        end else if (c >= "a" && c <= "z") begin
            cur = 6'(c - "a" + 8'd26);
        end else if (c >= "0" && c <= "9") begin
            cur = 6'(c - "0" + 8'd52);
        end else if (c == "+" || c == "-") begin
            cur = SEXTET_PLUS;
        end else if (c == "/" || c == "_") begin
            cur = SEXTET_SLASH;
        end else begin
            cur = SEXTET_INVALID;
            ok  = 1'b0;
        end
        case (group_pos)
            POS_SECOND: b = {prev_sextet, cur[5:4]};
            POS_THIRD:  b = {prev_sextet[3:0], cur[5:2]};
            POS_FOURTH: b = {prev_sextet[1:0], cur};
            default:    b = 8'h00;
        endcase
        has_byte = ok && (group_pos != POS_FIRST);
        if (req.is_last) begin
            group_pos   = POS_FIRST;
            prev_sextet = '0;
        end else begin
            group_pos   = group_pos + 2'd1;
            prev_sextet = cur;
        end
        chars_seen++;
        if (has_byte || req.is_last) begin
            res.byte_out      = has_byte ? b : 8'h00;
            res.byte_valid    = has_byte;
            res.end_of_string = req.is_last;
            pending_q = {pending_q, res};
        end
    endfunction

    task report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    task check_output(input t_out_item got);
        t_out_item want;
        if (pending_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", got));
        end else begin
            want = pending_q.pop_front();
            if (got.byte_out !== want.byte_out)
                report_mismatch($sformatf("byte_out %h, want %h", got.byte_out, want.byte_out));
            if (got.byte_valid !== want.byte_valid)
                report_mismatch($sformatf("byte_valid %b, want %b",
                                          got.byte_valid, want.byte_valid));
            if (got.end_of_string !== want.end_of_string)
                report_mismatch($sformatf("end_of_string %b, want %b",
                                          got.end_of_string, want.end_of_string));
            if (got.byte_valid)
                bytes_seen++;
            if (got.end_of_string)
                ends_seen++;
        end
    endtask
endclass

module base64_stream_decoder_top_tb;

    localparam int unsigned HOLD_CYCLES    = 64;
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned RANDOM_ITEMS   = 680;
    localparam int unsigned QUIET_ITEMS    = 100;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_item;

    decode_tracker tracker = new();

    int unsigned idle_pct     = 30;
    bit          hold_off_req = 1'b0;
    int unsigned holds_done   = 0;

    base64_stream_decoder_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int unsigned pick_gap();
        return ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 16) : 0;
    endfunction

    task automatic send_char(input t_in_item req, input int unsigned gap);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tracker.note_char(req);
    endtask

    // String of random sextet characters, optionally ending in '=' padding.
    task automatic send_string(input int unsigned len, input bit pad);
        t_in_item    req;
        logic [5:0]  v;
        bit          alt;
        int unsigned pads;
        int unsigned k;
        pads = pad ? $urandom_range(1, 2) : 0;
        if (pads >= len)
            pads = 0;
        for (k = 0; k < len; k++) begin
            v   = 6'($urandom_range(0, 63));
            alt = $urandom_range(0, 1);
            if (k >= len - pads)
                req.char_in = "=";
            else if (v < 26)
                req.char_in = "A" + 8'(v);
            else if (v < 52)
                req.char_in = "a" + 8'(v - 26);
            else if (v < 62)
                req.char_in = "0" + 8'(v - 52);
            else if (v == SEXTET_PLUS)
                req.char_in = alt ? "-" : "+";
            else
                req.char_in = alt ? "_" : "/";
            req.is_last = (k == len - 1);
            send_char(req, pick_gap());
        end
    endtask

    // Raw bytes with random end flags; hits the invalid range and broken groups.
    task automatic send_noise(input int unsigned len);
        t_in_item    req;
        int unsigned k;
        for (k = 0; k < len; k++) begin
            req.char_in = 8'($urandom_range(0, 255));
            req.is_last = ($urandom_range(0, 5) == 0);
            send_char(req, pick_gap());
        end
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin : receiver
        int unsigned n;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                holds_done++;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (i_rst_n && $urandom_range(0, 99) < idle_pct) begin
                n = $urandom_range(1, 16);
                i_out_stall <= 1'b1;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            tracker.check_output(o_out_item);
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin : main
        t_in_item    directed[$];
        int unsigned start;
        bit          pressed;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_item  = '0;
        pressed    = 1'b0;
        directed = '{
            '{"A", 1'b1},
            '{"T", 1'b0}, '{"W", 1'b0}, '{"F", 1'b0}, '{"u", 1'b0},
            '{"-", 1'b0}, '{"_", 1'b0}, '{"+", 1'b0}, '{"/", 1'b0},
            '{8'h00, 1'b0}, '{8'hff, 1'b0}, '{"z", 1'b0}, '{"9", 1'b0},
            '{"0", 1'b0}, '{"Z", 1'b0}, '{"a", 1'b0}, '{8'h80, 1'b1},
            '{"Q", 1'b0}, '{"Q", 1'b0}, '{"=", 1'b0}, '{"=", 1'b1},
            '{8'h7f, 1'b0}, '{"/", 1'b1},
            '{"g", 1'b0}, '{"@", 1'b1}
        };
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k])
            send_char(directed[k], pick_gap());

        start = tracker.chars_seen;
        while (tracker.chars_seen - start < RANDOM_ITEMS) begin
            if (tracker.chars_seen - start >= RANDOM_ITEMS - QUIET_ITEMS) begin
                idle_pct = 0;
            end else if (!pressed && tracker.chars_seen - start > 150) begin
                // Keep offering gap-free while the output is held off.
                pressed      = 1'b1;
                idle_pct     = 0;
                hold_off_req = 1'b1;
                send_string(24, 1'b0);
            end else if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 3))
                    0:       idle_pct = 0;
                    1:       idle_pct = 10;
                    2:       idle_pct = 30;
                    default: idle_pct = 60;
                endcase
            end
            if ($urandom_range(0, 4) == 0)
                send_noise($urandom_range(1, 8));
            else
                send_string($urandom_range(1, 12), $urandom_range(0, 1));
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (tracker.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d characters (directed groups, padding, both alphabets, raw bytes).",
                 tracker.chars_seen);
        $display("Checked %0d bytes and %0d string ends; %0d long output hold-off(s).",
                 tracker.bytes_seen, tracker.ends_seen, holds_done);
        if (tracker.mismatches == 0 && tracker.pending_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
